/* rtl/uvs_pkg.sv */
// shared types, constants and helper functions for the uv sphere vertex generator
package uvs_pkg;

  // sizes
  localparam int MaxDivisions = 1024;
  localparam int CountW       = $clog2(MaxDivisions) + 1;
  localparam int IdxW         = CountW - 1;
  localparam int AngleBits    = 16;
  localparam int QuotW        = AngleBits + 1;
  localparam int DividendW    = CountW + AngleBits;
  localparam int RadW         = 24;
  localparam int PosW         = 25;
  localparam int NormW        = 16;
  localparam int TexW         = 17;
  localparam int CW           = 33;
  localparam int CordicSteps  = 28;
  localparam int VtxPerQuad   = 6;
  localparam int VtxCntW      = $clog2(VtxPerQuad);

  localparam logic [VtxCntW-1:0] VtxLast = VtxCntW'(VtxPerQuad - 1);
  localparam logic signed [CW-1:0] CordicGain = CW'(32'h26DD3B6A);

  // arctangent of 2^-i, 2^32 units per turn
  localparam logic [29:0] ATAN_TAB [CordicSteps] = '{
    30'h20000000, 30'h12E4051E, 30'h09FB385B, 30'h051111D4, 30'h028B0D43, 30'h0145D7E1,
    30'h00A2F61E, 30'h00517C55, 30'h0028BE53, 30'h00145F2F, 30'h000A2F98, 30'h000517CC,
    30'h00028BE6, 30'h000145F3, 30'h0000A2FA, 30'h0000517D, 30'h000028BE, 30'h0000145F,
    30'h00000A30, 30'h00000518, 30'h0000028C, 30'h00000146, 30'h000000A3, 30'h00000051,
    30'h00000029, 30'h00000014, 30'h0000000A, 30'h00000005
  };

  // configuration register indexes
  typedef enum logic [1:0] {
    RegRadius = 2'd0,
    RegSlices = 2'd1,
    RegStacks = 2'd2
  } cfg_reg_e;

  typedef logic [CountW-1:0] cnt_t;
  typedef logic [IdxW-1:0]   idx_t;
  typedef logic [AngleBits-1:0] ph_t;

  // one clamped quad request
  typedef struct packed {
    idx_t stack;
    idx_t slice;
  } item_t;

  // one vertex entering the divider
  typedef struct packed {
    logic  vld;
    logic  last;
    cnt_t  k_lat;
    cnt_t  k_lon;
  } vtx_t;

  // per-vertex sideband carried along the pipeline
  typedef struct packed {
    logic            vld;
    logic            last;
    logic [TexW-1:0] u;
    logic [TexW-1:0] v;
  } tag_t;

  typedef struct packed {
    tag_t tag;
    ph_t  lat_ph;
    ph_t  lon_ph;
  } div_out_t;

  typedef struct packed {
    tag_t                  tag;
    logic signed [CW-1:0]  cl;
    logic signed [CW-1:0]  sl;
    logic signed [CW-1:0]  co;
    logic signed [CW-1:0]  so;
  } cord_out_t;

  typedef struct packed {
    logic lat_hi;
    logic lon_hi;
  } vtx_sel_t;

  // zero acts as one, large counts are capped
  function automatic cnt_t eff_count(input cnt_t v);
    if (v == '0) begin
      return CountW'(1);
    end else if (v > CountW'(MaxDivisions)) begin
      return CountW'(MaxDivisions);
    end else begin
      return v;
    end
  endfunction

  // corner order C, A, B, B, D, C
  function automatic vtx_sel_t vtx_sel(input logic [VtxCntW-1:0] c);
    vtx_sel_t r;
    case (c)
      3'd0: r = '{lat_hi: 1'b1, lon_hi: 1'b1};
      3'd1: r = '{lat_hi: 1'b1, lon_hi: 1'b0};
      3'd2: r = '{lat_hi: 1'b0, lon_hi: 1'b0};
      3'd3: r = '{lat_hi: 1'b0, lon_hi: 1'b0};
      3'd4: r = '{lat_hi: 1'b0, lon_hi: 1'b1};
      default: r = '{lat_hi: 1'b1, lon_hi: 1'b1};
    endcase
    return r;
  endfunction

endpackage

/* rtl/uvs_front.sv */
// request intake: index clamping and a two-entry request queue
module uvs_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  uvs_pkg::idx_t  stack_index_i,
  input  uvs_pkg::idx_t  slice_index_i,
  input  uvs_pkg::cnt_t  n_lat_i,
  input  uvs_pkg::cnt_t  n_lon_i,
  input  logic           pop_i,
  output logic           item_vld_o,
  output uvs_pkg::item_t item_o
);
  import uvs_pkg::*;

  localparam int Depth = 2;
  localparam int PtrW  = $clog2(Depth);

  item_t           mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [PtrW:0]   fill_q;
  logic            push;
  item_t           clamped;

  // index at or above the count goes to the last band
  function automatic idx_t clamp_idx(input idx_t i, input cnt_t n);
    cnt_t nm1;
    nm1 = n - CountW'(1);
    if ({1'b0, i} >= n) begin
      return nm1[IdxW-1:0];
    end else begin
      return i;
    end
  endfunction

  assign in_ready_o = (fill_q != (PtrW+1)'(Depth));
  assign push       = in_valid_i && in_ready_o;
  assign item_vld_o = (fill_q != '0);
  assign item_o     = mem_q[rd_q];

  always_comb begin
    clamped.stack = clamp_idx(stack_index_i, n_lat_i);
    clamped.slice = clamp_idx(slice_index_i, n_lon_i);
  end

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= clamped;
    end
  end

  // queue pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q   <= '0;
      rd_q   <= '0;
      fill_q <= '0;
    end else begin
      if (push) begin
        wr_q <= wr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_q <= rd_q + PtrW'(1);
      end
      case ({push, pop_i})
        2'b10:   fill_q <= fill_q + (PtrW+1)'(1);
        2'b01:   fill_q <= fill_q - (PtrW+1)'(1);
        default: fill_q <= fill_q;
      endcase
    end
  end

endmodule

/* rtl/uvs_seq.sv */
// vertex sequencer: expands one quad into its six corner vertices
module uvs_seq (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           item_vld_i,
  input  uvs_pkg::item_t item_i,
  output logic           pop_o,
  input  logic           adv_i,
  output uvs_pkg::vtx_t  vtx_o
);
  import uvs_pkg::*;

  item_t               cur_q;
  logic                busy_q;
  logic [VtxCntW-1:0]  cnt_q;
  logic                emit, fin;
  vtx_sel_t            sel;

  assign emit  = busy_q && adv_i;
  assign fin   = emit && (cnt_q == VtxLast);
  assign pop_o = item_vld_i && (!busy_q || fin);

  // current vertex
  always_comb begin
    sel         = vtx_sel(cnt_q);
    vtx_o.vld   = busy_q;
    vtx_o.last  = (cnt_q == VtxLast);
    vtx_o.k_lat = {1'b0, cur_q.stack} + CountW'(sel.lat_hi);
    vtx_o.k_lon = {1'b0, cur_q.slice} + CountW'(sel.lon_hi);
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_q <= item_i;
    end
  end

  // corner counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (pop_o) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (fin) begin
      busy_q <= 1'b0;
    end else if (emit) begin
      cnt_q <= cnt_q + VtxCntW'(1);
    end
  end

endmodule

/* rtl/uvs_div.sv */
// pipelined restoring dividers: texture u (also the longitude phase), texture v and latitude phase
module uvs_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  uvs_pkg::vtx_t     vtx_i,
  input  uvs_pkg::cnt_t     n_lat_i,
  input  uvs_pkg::cnt_t     n_lon_i,
  output uvs_pkg::div_out_t div_o
);
  import uvs_pkg::*;

  localparam int NumLanes = 3;
  localparam int Stages   = QuotW;
  localparam ph_t QuarterTurn = ph_t'(1) << (AngleBits - 2);

  typedef struct packed {
    cnt_t             rem;
    logic [QuotW-1:0] w;
  } dstep_t;

  dstep_t                  st_q   [Stages][NumLanes];
  logic [1:0]              ctl_q  [Stages];
  logic [DividendW-1:0]    dvd    [NumLanes];
  cnt_t                    den    [NumLanes];

  // one quotient bit: the top of w is the next dividend bit
  function automatic dstep_t div_step(input dstep_t a, input cnt_t n);
    logic [CountW:0] r2, df;
    dstep_t          r;
    r2 = {a.rem, a.w[QuotW-1]};
    df = r2 - {1'b0, n};
    if (r2 >= {1'b0, n}) begin
      r.rem = df[CountW-1:0];
      r.w   = {a.w[QuotW-2:0], 1'b1};
    end else begin
      r.rem = r2[CountW-1:0];
      r.w   = {a.w[QuotW-2:0], 1'b0};
    end
    return r;
  endfunction

  // dividends: k * 2^16 + n/2 for texture, k * 2^15 + n/2 for latitude
  always_comb begin
    den[0] = n_lon_i;
    den[1] = n_lat_i;
    den[2] = n_lat_i;
    dvd[0] = {vtx_i.k_lon, AngleBits'(0)} + DividendW'(n_lon_i >> 1);
    dvd[1] = {vtx_i.k_lat, AngleBits'(0)} + DividendW'(n_lat_i >> 1);
    dvd[2] = {1'b0, vtx_i.k_lat, (AngleBits-1)'(0)} + DividendW'(n_lat_i >> 1);
  end

  for (genvar s = 0; s < Stages; s++) begin : g_stage
    for (genvar l = 0; l < NumLanes; l++) begin : g_lane
      dstep_t din;
      if (s == 0) begin : g_first
        assign din.rem = CountW'(dvd[l][DividendW-1:QuotW]);
        assign din.w   = dvd[l][QuotW-1:0];
      end else begin : g_next
        assign din = st_q[s-1][l];
      end
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          st_q[s][l] <= div_step(din, den[l]);
        end
      end
    end

    // valid and last travel with the data
    if (s == 0) begin : g_ctl_first
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          ctl_q[s] <= '0;
        end else if (en_i) begin
          ctl_q[s] <= {vtx_i.vld, vtx_i.last};
        end
      end
    end else begin : g_ctl_next
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          ctl_q[s] <= '0;
        end else if (en_i) begin
          ctl_q[s] <= ctl_q[s-1];
        end
      end
    end
  end

  always_comb begin
    div_o.tag.vld  = ctl_q[Stages-1][1];
    div_o.tag.last = ctl_q[Stages-1][0];
    div_o.tag.u    = st_q[Stages-1][0].w;
    div_o.tag.v    = st_q[Stages-1][1].w;
    div_o.lon_ph   = st_q[Stages-1][0].w[AngleBits-1:0];
    div_o.lat_ph   = st_q[Stages-1][2].w[AngleBits-1:0] - QuarterTurn;
  end

endmodule

/* rtl/uvs_cordic.sv */
// pipelined rotation cordic for latitude and longitude sin and cos
module uvs_cordic (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  uvs_pkg::div_out_t  div_i,
  output uvs_pkg::cord_out_t cord_o
);
  import uvs_pkg::*;

  localparam int NumLanes = 2;

  typedef struct packed {
    logic signed [CW-1:0] c;
    logic signed [CW-1:0] s;
  } cs_t;

  logic signed [CW-1:0] x_q [CordicSteps][NumLanes];
  logic signed [CW-1:0] y_q [CordicSteps][NumLanes];
  logic signed [CW-1:0] z_q [CordicSteps][NumLanes];
  logic [1:0]           q_q [CordicSteps][NumLanes];
  tag_t                 tag_q [CordicSteps];
  ph_t                  ph  [NumLanes];
  tag_t                 out_tag_q;
  logic signed [CW-1:0] out_cl_q, out_sl_q, out_co_q, out_so_q;
  cs_t                  cs_lat, cs_lon;

  // fold the quadrant back in
  function automatic cs_t quad_map(input logic [1:0] q, input logic signed [CW-1:0] x,
                                   input logic signed [CW-1:0] y);
    cs_t r;
    case (q)
      2'd0:    begin r.c = x;  r.s = y;  end
      2'd1:    begin r.c = -y; r.s = x;  end
      2'd2:    begin r.c = -x; r.s = -y; end
      default: begin r.c = y;  r.s = -x; end
    endcase
    return r;
  endfunction

  assign ph[0] = div_i.lat_ph;
  assign ph[1] = div_i.lon_ph;

  for (genvar s = 0; s < CordicSteps; s++) begin : g_step
    localparam logic signed [CW-1:0] AtanS = CW'(ATAN_TAB[s]);
    for (genvar l = 0; l < NumLanes; l++) begin : g_lane
      logic signed [CW-1:0] xi, yi, zi, xo, yo, zo;
      logic [1:0]           qi;
      if (s == 0) begin : g_first
        assign xi = CordicGain;
        assign yi = '0;
        assign zi = $signed({3'b000, ph[l][AngleBits-3:0], (32-AngleBits)'(0)});
        assign qi = ph[l][AngleBits-1:AngleBits-2];
      end else begin : g_next
        assign xi = x_q[s-1][l];
        assign yi = y_q[s-1][l];
        assign zi = z_q[s-1][l];
        assign qi = q_q[s-1][l];
      end
      // rotate toward zero residual angle
      always_comb begin
        if (!zi[CW-1]) begin
          xo = xi - (yi >>> s);
          yo = yi + (xi >>> s);
          zo = zi - AtanS;
        end else begin
          xo = xi + (yi >>> s);
          yo = yi - (xi >>> s);
          zo = zi + AtanS;
        end
      end
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          x_q[s][l] <= xo;
          y_q[s][l] <= yo;
          z_q[s][l] <= zo;
          q_q[s][l] <= qi;
        end
      end
    end

    // sideband
    if (s == 0) begin : g_tag_first
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          tag_q[s] <= '0;
        end else if (en_i) begin
          tag_q[s] <= div_i.tag;
        end
      end
    end else begin : g_tag_next
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          tag_q[s] <= '0;
        end else if (en_i) begin
          tag_q[s] <= tag_q[s-1];
        end
      end
    end
  end

  // quadrant correction stage
  always_comb begin
    cs_lat = quad_map(q_q[CordicSteps-1][0], x_q[CordicSteps-1][0], y_q[CordicSteps-1][0]);
    cs_lon = quad_map(q_q[CordicSteps-1][1], x_q[CordicSteps-1][1], y_q[CordicSteps-1][1]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_tag_q <= '0;
    end else if (en_i) begin
      out_tag_q <= tag_q[CordicSteps-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      out_cl_q <= cs_lat.c;
      out_sl_q <= cs_lat.s;
      out_co_q <= cs_lon.c;
      out_so_q <= cs_lon.s;
    end
  end

  always_comb begin
    cord_o.tag = out_tag_q;
    cord_o.cl  = out_cl_q;
    cord_o.sl  = out_sl_q;
    cord_o.co  = out_co_q;
    cord_o.so  = out_so_q;
  end

endmodule

/* rtl/uv_sphere_quad_vertex_generator.sv */
// top level: configuration registers, quad intake, vertex pipeline and output register
//
//   channel  | signals                                 | direction
//   request  | in_valid_i/in_ready_o, stack/slice index| in
//   vertex   | out_valid_o/out_ready_i, pos/norm/tex   | out
//   config   | cfg_we_i, cfg_idx_i, cfg_data_i         | in
//
// One vertex leaves per cycle through the single output register while the
// output is not stalled; a request passes the request queue, the sequencer
// register, 17 divider stages, 29 cordic stages, two multiply stages and the
// output register.
// Reset clears control state and loads the configuration defaults; no memory clearing pass.
// An output stall freezes the whole vertex pipeline; the two-entry request
// queue keeps taking requests meanwhile until it is full.
module uv_sphere_quad_vertex_generator (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [1:0]                          cfg_idx_i,
  input  logic [uvs_pkg::RadW-1:0]            cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [uvs_pkg::IdxW-1:0]            stack_index_i,
  input  logic [uvs_pkg::IdxW-1:0]            slice_index_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [uvs_pkg::PosW-1:0]     pos_x_o,
  output logic signed [uvs_pkg::PosW-1:0]     pos_y_o,
  output logic signed [uvs_pkg::PosW-1:0]     pos_z_o,
  output logic signed [uvs_pkg::NormW-1:0]    norm_x_o,
  output logic signed [uvs_pkg::NormW-1:0]    norm_y_o,
  output logic signed [uvs_pkg::NormW-1:0]    norm_z_o,
  output logic [uvs_pkg::TexW-1:0]            tex_u_o,
  output logic [uvs_pkg::TexW-1:0]            tex_v_o,
  output logic                                last_vertex_o
);
  import uvs_pkg::*;

  localparam int PW  = RadW + 1 + CW;
  localparam int RpW = PW - 30;
  localparam int NqW = CW - 15;
  localparam logic signed [2*CW-1:0] RndQ30 = (2*CW)'(1) << 29;
  localparam logic signed [PW-1:0]   RndPos = PW'(1) << 29;
  localparam logic signed [CW-1:0]   RndQ15 = CW'(1) << 14;
  localparam logic signed [RpW-1:0]  PosMax = RpW'((1 << (PosW-1)) - 1);
  localparam logic signed [RpW-1:0]  PosMin = -RpW'(1 << (PosW-1));
  localparam logic signed [NqW-1:0]  NrmMax = NqW'((1 << (NormW-1)) - 1);
  localparam logic signed [NqW-1:0]  NrmMin = -NqW'(1 << (NormW-1));

  logic [RadW-1:0] radius_q;
  cnt_t            slices_q, stacks_q, n_lat, n_lon;
  logic            adv, item_vld, pop;
  item_t           item;
  vtx_t            vtx;
  div_out_t        div_out;
  cord_out_t       cord;

  tag_t                  m1_tag_q, m2_tag_q;
  logic signed [CW-1:0]  m1_n_q [3];
  logic signed [PW-1:0]  m2_p_q [3];
  logic signed [NormW-1:0] m2_nq_q [3];
  logic signed [2*CW-1:0] p_sc, p_cc;
  logic signed [CW-1:0]  n_d [3];
  logic signed [PW-1:0]  p_d [3];
  logic signed [NormW-1:0] nq_d [3];
  logic signed [PosW-1:0] pos_d [3];

  logic                  out_vld_q;
  tag_t                  out_tag_q;
  logic signed [PosW-1:0]  out_pos_q [3];
  logic signed [NormW-1:0] out_nrm_q [3];

  function automatic logic signed [CW-1:0] round_q30(input logic signed [2*CW-1:0] p);
    logic signed [2*CW-1:0] t;
    t = p + RndQ30;
    return t[CW+29:30];
  endfunction

  function automatic logic signed [NormW-1:0] norm_q15(input logic signed [CW-1:0] n);
    logic signed [CW-1:0]  t;
    logic signed [NqW-1:0] q;
    t = n + RndQ15;
    q = t[CW-1:15];
    if (q > NrmMax) begin
      return NrmMax[NormW-1:0];
    end else if (q < NrmMin) begin
      return NrmMin[NormW-1:0];
    end else begin
      return q[NormW-1:0];
    end
  endfunction

  function automatic logic signed [PosW-1:0] pos_round(input logic signed [PW-1:0] p);
    logic signed [PW-1:0]  t;
    logic signed [RpW-1:0] r;
    t = p + RndPos;
    r = t[PW-1:30];
    if (r > PosMax) begin
      return PosMax[PosW-1:0];
    end else if (r < PosMin) begin
      return PosMin[PosW-1:0];
    end else begin
      return r[PosW-1:0];
    end
  endfunction

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= RadW'(32'h10000);
      slices_q <= CountW'(16);
      stacks_q <= CountW'(16);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegRadius: radius_q <= cfg_data_i;
        RegSlices: slices_q <= cfg_data_i[CountW-1:0];
        RegStacks: stacks_q <= cfg_data_i[CountW-1:0];
        default: ;
      endcase
    end
  end

  assign n_lat = eff_count(stacks_q);
  assign n_lon = eff_count(slices_q);

  // whole vertex pipeline moves when the output slot is free or drained
  assign adv = !out_vld_q || out_ready_i;

  uvs_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .stack_index_i (stack_index_i),
    .slice_index_i (slice_index_i),
    .n_lat_i       (n_lat),
    .n_lon_i       (n_lon),
    .pop_i         (pop),
    .item_vld_o    (item_vld),
    .item_o        (item)
  );

  uvs_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .item_vld_i (item_vld),
    .item_i     (item),
    .pop_o      (pop),
    .adv_i      (adv),
    .vtx_o      (vtx)
  );

  uvs_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .vtx_i   (vtx),
    .n_lat_i (n_lat),
    .n_lon_i (n_lon),
    .div_o   (div_out)
  );

  uvs_cordic u_cordic (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .div_i  (div_out),
    .cord_o (cord)
  );

  // unit normal: cos lat times sin/cos lon for x and z, sin lat for y
  always_comb begin
    p_sc   = cord.cl * cord.so;
    p_cc   = cord.cl * cord.co;
    n_d[0] = round_q30(p_sc);
    n_d[1] = cord.sl;
    n_d[2] = round_q30(p_cc);
  end

  // radius products and q1.15 normals
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      p_d[a]  = $signed({1'b0, radius_q}) * m1_n_q[a];
      nq_d[a] = norm_q15(m1_n_q[a]);
    end
  end

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      pos_d[a] = pos_round(m2_p_q[a]);
    end
  end

  // multiply stages and output register, payload
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int a = 0; a < 3; a++) begin
        m1_n_q[a]    <= n_d[a];
        m2_p_q[a]    <= p_d[a];
        m2_nq_q[a]   <= nq_d[a];
        out_pos_q[a] <= pos_d[a];
        out_nrm_q[a] <= m2_nq_q[a];
      end
    end
  end

  // multiply stages and output register, control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m1_tag_q  <= '0;
      m2_tag_q  <= '0;
      out_tag_q <= '0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      m1_tag_q  <= cord.tag;
      m2_tag_q  <= m1_tag_q;
      out_tag_q <= m2_tag_q;
      out_vld_q <= m2_tag_q.vld;
    end
  end

  assign out_valid_o   = out_vld_q;
  assign pos_x_o       = out_pos_q[0];
  assign pos_y_o       = out_pos_q[1];
  assign pos_z_o       = out_pos_q[2];
  assign norm_x_o      = out_nrm_q[0];
  assign norm_y_o      = out_nrm_q[1];
  assign norm_z_o      = out_nrm_q[2];
  assign tex_u_o       = out_tag_q.u;
  assign tex_v_o       = out_tag_q.v;
  assign last_vertex_o = out_tag_q.last;

endmodule

/* rtl/uvs_checker.sv */
// port-level checks for the uv sphere vertex generator and their binding
module uvs_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             out_valid_o,
  input logic                             out_ready_i,
  input logic signed [uvs_pkg::PosW-1:0]  pos_x_o,
  input logic signed [uvs_pkg::PosW-1:0]  pos_y_o,
  input logic signed [uvs_pkg::NormW-1:0] norm_y_o,
  input logic [uvs_pkg::TexW-1:0]         tex_u_o,
  input logic [uvs_pkg::TexW-1:0]         tex_v_o
);
  import uvs_pkg::*;

  // a stalled vertex stays offered
  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("vertex dropped while stalled");

  // a stalled vertex keeps its x position
  a_hold_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(pos_x_o))
    else $error("vertex position changed while stalled");

  // texture coordinates never pass 1.0
  a_tex_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (tex_u_o <= 17'd65536) && (tex_v_o <= 17'd65536))
    else $error("texture coordinate above one");

  // a southern normal never gives a northern position
  a_pos_sign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && norm_y_o[NormW-1] |-> pos_y_o[PosW-1] || (pos_y_o == '0))
    else $error("position y disagrees with normal y");

endmodule

bind uv_sphere_quad_vertex_generator uvs_checker u_uvs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .pos_x_o     (pos_x_o),
  .pos_y_o     (pos_y_o),
  .norm_y_o    (norm_y_o),
  .tex_u_o     (tex_u_o),
  .tex_v_o     (tex_v_o)
);
